FILE: src/cla_pkg.sv
// Shared types, constants and helper functions of the command line assembler.
package cla_pkg;

    localparam int BUF_SIZE   = 64;
    localparam int ADDR_W     = $clog2(BUF_SIZE);
    localparam int COUNT_W    = 6;
    localparam int ABORT_LEN  = 5;
    localparam int LETTER_W   = 3;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_TAKE    = 2'd1,
        OP_ABORT   = 2'd2,
        OP_RESTART = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        K_STATUS = 3'd0,
        K_CHAR   = 3'd1,
        K_EMPTY  = 3'd2,
        K_NONE   = 3'd3,
        K_ABORT  = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [7:0]           line_char;
        logic                 last;
        logic [COUNT_W-1:0]   char_count;
        logic                 line_ready;
        logic                 cr_seen;
        logic                 overflowed;
        logic                 abort_match;
    } result_t;

    typedef struct packed {
        logic is_blank;
        logic is_cr;
        logic is_lf;
        logic letter_match;
    } char_class_t;

    // Lowercase letters of the abort keyword, by position.
    function automatic logic [7:0] abort_letter(input logic [LETTER_W-1:0] pos);
        logic [7:0] ch;
        begin
            case (pos)
                3'd0:    ch = 8'h61;
                3'd1:    ch = 8'h62;
                3'd2:    ch = 8'h6F;
                3'd3:    ch = 8'h72;
                3'd4:    ch = 8'h74;
                default: ch = 8'hFF;
            endcase
            return ch;
        end
    endfunction

endpackage

FILE: src/cla_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/cla_char_unit.sv
// Shared character classifier: control codes, blanks and case-folded keyword compare.
module cla_char_unit
    import cla_pkg::*;
(
    input  logic [7:0]          ch,
    input  logic [LETTER_W-1:0] letter_pos,
    output char_class_t         cls
);

    logic [7:0] folded;

    always_comb
    begin
        folded = ch;
        if (ch >= 8'h41 && ch <= 8'h5A)
        begin
            folded = ch + 8'h20;
        end
        cls.is_blank     = (ch == CH_SPACE) || (ch == CH_TAB);
        cls.is_cr        = (ch == CH_CR);
        cls.is_lf        = (ch == CH_LF);
        cls.letter_match = (folded == abort_letter(letter_pos));
    end

endmodule

FILE: src/command_line_assembler.sv
// Top level of the command line assembler: sequencer, line state and output register.
// Sequencing: a byte, restart or short-cut result passes through EXEC and EMIT into the output
// register, EMIT waiting until that register is free; a new input transfer is taken once the
// sequencer is back idle. Throughput: a take streams one character per cycle after the first
// read while the output register is free, and an abort check over the stored characters walks
// the line buffer once, one read per cycle.
// Reset clears the count, flags, sequencer and output valid; the line buffer is not cleared.
module command_line_assembler
    import cla_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] line_char, [13:8] char_count,
                                        // [14] line_ready, [15] cr_seen,
                                        // [16] overflowed, [17] abort_match, [23:18] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast    // last result of the input item
);

    // One-hot sequencer states. IDLE takes a transfer, EXEC decodes the operation,
    // EMIT hands a single result to the output register, TAKE streams the stored
    // characters and SCAN walks the buffer for the abort keyword.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_EMIT = 5'b00100,
        S_TAKE = 5'b01000,
        S_SCAN = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    opcode_t             op_reg, op_next;
    logic [7:0]          byte_reg, byte_next;
    logic [COUNT_W-1:0]  total_reg, total_next;
    logic                cr_reg, cr_next;
    logic                done_reg, done_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic                found_reg, found_next;
    logic [LETTER_W-1:0] off_reg, off_next;
    logic                mism_reg, mism_next;
    logic                tail_reg, tail_next;
    result_t             pend_reg, pend_next;
    result_t             out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic                s_accept;
    logic                out_free;
    logic [7:0]          unit_ch;
    char_class_t         cls;
    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [7:0]          ram_rdata;
    logic                take_last;
    logic                abort_hit;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // The one classifier serves the received byte during EXEC and buffer reads during SCAN.
    assign unit_ch = (state_reg == S_SCAN) ? ram_rdata : byte_reg;

    cla_char_unit u_char (
        .ch         (unit_ch),
        .letter_pos (off_reg),
        .cls        (cls)
    );

    cla_ram #(
        .WIDTH (8),
        .DEPTH (BUF_SIZE)
    ) u_line_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (total_reg[ADDR_W-1:0]),
        .wdata (byte_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign take_last = ((idx_reg + 1'b1) == pend_reg.char_count[ADDR_W-1:0]);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        byte_next      = byte_reg;
        total_next     = total_reg;
        cr_next        = cr_reg;
        done_next      = done_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        off_next       = off_reg;
        mism_next      = mism_reg;
        tail_next      = tail_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        abort_hit      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    op_next    = opcode_t'(s_axis_tuser);
                    byte_next  = s_axis_tdata;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                pend_next            = '0;
                pend_next.last       = 1'b1;
                pend_next.char_count = total_reg;
                pend_next.line_ready = done_reg;
                pend_next.cr_seen    = cr_reg;
                state_next           = S_EMIT;
                case (op_reg)
                    OP_BYTE:
                    begin
                        pend_next.kind = K_STATUS;
                        if (!done_reg)
                        begin
                            if (cls.is_cr)
                            begin
                                cr_next = 1'b1;
                            end
                            else if (cls.is_lf)
                            begin
                                done_next = 1'b1;
                            end
                            else if (total_reg < COUNT_W'(BUF_SIZE - 1))
                            begin
                                ram_we     = 1'b1;
                                total_next = total_reg + 1'b1;
                            end
                            else
                            begin
                                // The buffer is full: the whole line is dropped.
                                total_next           = '0;
                                cr_next              = 1'b0;
                                done_next            = 1'b0;
                                pend_next.overflowed = 1'b1;
                            end
                        end
                        pend_next.char_count = total_next;
                        pend_next.line_ready = done_next;
                        pend_next.cr_seen    = cr_next;
                    end

                    OP_TAKE:
                    begin
                        if (!done_reg)
                        begin
                            pend_next.kind = K_NONE;
                        end
                        else
                        begin
                            total_next = '0;
                            cr_next    = 1'b0;
                            done_next  = 1'b0;
                            if (total_reg == '0)
                            begin
                                pend_next.kind = K_EMPTY;
                            end
                            else
                            begin
                                pend_next.kind = K_CHAR;
                                idx_next       = '0;
                                ram_re         = 1'b1;
                                ram_raddr      = '0;
                                state_next     = S_TAKE;
                            end
                        end
                    end

                    OP_ABORT:
                    begin
                        pend_next.kind = K_ABORT;
                        if (done_reg && (total_reg != '0))
                        begin
                            idx_next   = '0;
                            found_next = 1'b0;
                            off_next   = '0;
                            mism_next  = 1'b0;
                            tail_next  = 1'b0;
                            ram_re     = 1'b1;
                            ram_raddr  = '0;
                            state_next = S_SCAN;
                        end
                    end

                    OP_RESTART:
                    begin
                        total_next           = '0;
                        cr_next              = 1'b0;
                        done_next            = 1'b0;
                        pend_next.kind       = K_STATUS;
                        pend_next.char_count = '0;
                        pend_next.line_ready = 1'b0;
                        pend_next.cr_seen    = 1'b0;
                    end

                    default:
                    begin
                        pend_next.kind = K_STATUS;
                    end
                endcase
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_TAKE:
            begin
                // Read data for idx_reg is held until the output register takes it.
                if (out_free)
                begin
                    out_next           = pend_reg;
                    out_next.line_char = ram_rdata;
                    out_next.last      = take_last;
                    out_valid_next     = 1'b1;
                    if (take_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next  = idx_reg + 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg + 1'b1;
                    end
                end
            end

            S_SCAN:
            begin
                // Leading blanks are skipped, the next five characters must spell the
                // keyword, and only blanks may follow them.
                if (!found_reg)
                begin
                    if (!cls.is_blank)
                    begin
                        found_next = 1'b1;
                        mism_next  = mism_reg || !cls.letter_match;
                        off_next   = off_reg + 1'b1;
                    end
                end
                else if (off_reg < LETTER_W'(ABORT_LEN))
                begin
                    mism_next = mism_reg || !cls.letter_match;
                    off_next  = off_reg + 1'b1;
                end
                else if (!cls.is_blank)
                begin
                    tail_next = 1'b1;
                end

                if ((idx_reg + 1'b1) == total_reg[ADDR_W-1:0])
                begin
                    abort_hit = found_next && (off_next == LETTER_W'(ABORT_LEN)) &&
                                !mism_next && !tail_next;
                    if (abort_hit)
                    begin
                        total_next = '0;
                        cr_next    = 1'b0;
                        done_next  = 1'b0;
                    end
                    pend_next.abort_match = abort_hit;
                    pend_next.char_count  = total_next;
                    pend_next.line_ready  = done_next;
                    pend_next.cr_seen     = cr_next;
                    state_next            = S_EMIT;
                end
                else
                begin
                    idx_next  = idx_reg + 1'b1;
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            cr_reg        <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            cr_reg        <= cr_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        byte_reg  <= byte_next;
        idx_reg   <= idx_next;
        found_reg <= found_next;
        off_reg   <= off_next;
        mism_reg  <= mism_next;
        tail_reg  <= tail_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {6'b0, out_reg.abort_match, out_reg.overflowed, out_reg.cr_seen,
                            out_reg.line_ready, out_reg.char_count, out_reg.line_char};

    // Once a transfer is taken, the sequencer is busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> !s_axis_tready)
        else $error("input taken while the previous item is still being decoded");

    // Only character results of a take can be followed by more results of the same item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != K_CHAR)) |-> m_axis_tlast)
        else $error("single result without the last mark");

    // The abort flag is only raised on an abort answer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[17]) |-> (m_axis_tuser == K_ABORT))
        else $error("abort flag on a result that is not an abort answer");

    // The buffer is written only while a received byte is decoded.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == S_EXEC) && (op_reg == OP_BYTE) && !done_reg))
        else $error("line buffer written outside byte decode");

endmodule

FILE: dv/tb_command_line_assembler.sv
// Self-checking testbench for the command line assembler stream block.
module tb_command_line_assembler;

    timeunit 1ns;
    timeprecision 1ps;

    import cla_pkg::*;

    // Generous bound on the whole run. The slowest legal run (every take streaming a
    // full line while the receiver stalls at random) stays far below this.
    localparam int CYCLE_LIMIT  = 300000;
    // Longest result burst is a take of a full line.
    localparam int DRAIN_CYCLES = 2 * BUF_SIZE;
    localparam int HOLD_CYCLES  = 400;
    localparam int TOTAL_ITEMS  = 350;
    localparam int REPORT_CAP   = 60;
    localparam int IDLE_PERCENT = 15;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] rx_byte
    logic [1:0]  s_axis_tuser;     // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;     // [7:0] line_char, [13:8] char_count, [14] line_ready,
                                   // [15] cr_seen, [16] overflowed, [17] abort_match
    logic [2:0]  m_axis_tuser;     // [2:0] kind
    logic        m_axis_tlast;

    // Shadow copy of the line state, advanced once per accepted input transfer.
    int          line_len;
    logic        line_cr;
    logic        line_done;
    logic [7:0]  line_chars [BUF_SIZE];

    // Results the block still owes us, oldest first.
    result_t     awaited_results [$];

    int          error_count;
    int          result_index;
    int          counted_items;
    int          cycle_count;
    bit          steady;          // suppresses random idling on both sides
    bit          hold_request;    // asks the receiver for one long hold-off
    int          hold_left;

    command_line_assembler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 4 ns clock period: 2 ns low, then 2 ns high.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Every mismatch goes through here. After the first few dozen lines only the count
    // grows, so a badly broken block cannot flood the log.
    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= REPORT_CAP)
        begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      result_index, name, got, want));
        end
    endtask

    function automatic void await_result(input kind_t kind, input logic [7:0] ch,
                                         input logic last, input int count,
                                         input logic ready, input logic cr,
                                         input logic ovf, input logic abort_hit);
        result_t r;
        r.kind        = kind;
        r.line_char   = ch;
        r.last        = last;
        r.char_count  = COUNT_W'(count);
        r.line_ready  = ready;
        r.cr_seen     = cr;
        r.overflowed  = ovf;
        r.abort_match = abort_hit;
        awaited_results.push_back(r);
    endfunction

    function automatic void clear_line();
        line_len  = 0;
        line_cr   = 1'b0;
        line_done = 1'b0;
    endfunction

    // True when the stored line, stripped of spaces and tabs at both ends, spells the
    // abort keyword in any mix of upper and lower case.
    function automatic logic line_says_abort();
        string      word = "abort";
        int         lo;
        int         hi;
        logic [7:0] c;
        lo = 0;
        hi = line_len;
        while (lo < hi && (line_chars[lo] == CH_SPACE || line_chars[lo] == CH_TAB))
            lo++;
        while (hi > lo && (line_chars[hi-1] == CH_SPACE || line_chars[hi-1] == CH_TAB))
            hi--;
        if (hi - lo != ABORT_LEN)
            return 1'b0;
        for (int i = 0; i < ABORT_LEN; i++)
        begin
            c = line_chars[lo + i];
            if (c >= 8'h41 && c <= 8'h5A)
                c = c + 8'h20;
            if (c != 8'(word[i]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advances the shadow line state by one command and queues the results it causes.
    function automatic void track_command(input opcode_t op, input logic [7:0] rx);
        logic ovf;
        logic hit;
        int   taken;
        logic was_cr;
        case (op)
            OP_BYTE:
            begin
                ovf = 1'b0;
                counted_items++;
                // Bytes that arrive after the line feed leave the line untouched.
                if (!line_done)
                begin
                    if (rx == CH_CR)
                        line_cr = 1'b1;
                    else if (rx == CH_LF)
                        line_done = 1'b1;
                    else if (line_len < BUF_SIZE - 1)
                    begin
                        line_chars[line_len] = rx;
                        line_len++;
                    end
                    else
                    begin
                        clear_line();
                        ovf = 1'b1;
                    end
                end
                await_result(K_STATUS, 8'h00, 1'b1, line_len, line_done, line_cr, ovf, 1'b0);
            end
            OP_TAKE:
            begin
                counted_items++;
                taken  = line_len;
                was_cr = line_cr;
                if (!line_done)
                    await_result(K_NONE, 8'h00, 1'b1, taken, 1'b0, was_cr, 1'b0, 1'b0);
                else if (taken == 0)
                    await_result(K_EMPTY, 8'h00, 1'b1, 0, 1'b1, was_cr, 1'b0, 1'b0);
                else
                begin
                    // The take streams the whole line, all results showing the state
                    // from before the line was cleared.
                    for (int i = 0; i < taken; i++)
                        await_result(K_CHAR, line_chars[i], i == taken - 1, taken,
                                     1'b1, was_cr, 1'b0, 1'b0);
                end
                if (line_done)
                    clear_line();
            end
            OP_ABORT:
            begin
                counted_items++;
                hit = line_done && line_says_abort();
                if (hit)
                    clear_line();
                await_result(K_ABORT, 8'h00, 1'b1, line_len, line_done, line_cr, 1'b0, hit);
            end
            default:
            begin
                counted_items++;
                clear_line();
                await_result(K_STATUS, 8'h00, 1'b1, 0, 1'b0, 1'b0, 1'b0, 1'b0);
            end
        endcase
    endfunction

    // Offers one command on the input side and returns at the falling edge after the
    // transfer. Valid is left high so back-to-back commands need no extra edge; it only
    // drops when a random idle gap is inserted or the run ends.
    task automatic send_item(input opcode_t op, input logic [7:0] rx);
        if (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= rx;
        do
            @(posedge clk);
        while (!s_axis_tready);
        track_command(op, rx);
        @(negedge clk);
    endtask

    task automatic send_text(input logic [7:0] text [$]);
        foreach (text[i])
            send_item(OP_BYTE, text[i]);
    endtask

    // One random sequence: mostly a well-formed line (plain text or an abort keyword
    // with random case and padding), finished mostly by a take, an abort check or a restart.
    // The rest is a single command of any kind with any data.
    task automatic send_random_sequence();
        string      word = "abort";
        logic [7:0] text [$];
        logic [7:0] c;
        int         pick;
        int         len;
        pick = $urandom_range(0, 99);
        if (pick >= 85)
        begin
            send_item(opcode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            return;
        end
        if (pick < 25)
        begin
            repeat ($urandom_range(0, 2))
                text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            for (int i = 0; i < ABORT_LEN; i++)
            begin
                c = 8'(word[i]);
                if ($urandom_range(0, 1))
                    c = c - 8'h20;
                text.push_back(c);
            end
            // Now and then spoil the keyword so that near misses are checked as well.
            case ($urandom_range(0, 7))
                0: text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(11, 255));
                1: void'(text.pop_back());
                2: text.push_back(8'h73);
                default: ;
            endcase
            repeat ($urandom_range(0, 2))
                text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        end
        else
        begin
            // Mostly short lines; a few run up to and past the buffer limit.
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(58, 66) : $urandom_range(0, 10);
            repeat (len)
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == CH_LF);
                text.push_back(c);
            end
        end
        if ($urandom_range(0, 1))
            text.insert($urandom_range(0, text.size()), CH_CR);
        if ($urandom_range(0, 9) != 0)
            text.push_back(CH_LF);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2))
                text.push_back(8'($urandom_range(0, 255)));
        send_text(text);
        pick = $urandom_range(0, 9);
        if (pick < 5)
            send_item(OP_TAKE, 8'($urandom_range(0, 255)));
        else if (pick < 8)
        begin
            send_item(OP_ABORT, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
                send_item(OP_TAKE, 8'($urandom_range(0, 255)));
        end
        else if (pick == 8)
            send_item(OP_RESTART, 8'($urandom_range(0, 255)));
    endtask

    // A take and an abort check straight out of reset find no line at all.
    task automatic test_no_line();
        send_item(OP_TAKE, 8'h00);
        send_item(OP_ABORT, 8'hFF);
    endtask

    // A line with only a carriage return: the abort check must not match it and the
    // take reports an empty line. A bare line feed also gives an empty take.
    task automatic test_empty_line();
        send_text('{CH_CR, CH_LF});
        send_item(OP_ABORT, 8'h00);
        send_item(OP_TAKE, 8'h00);
        send_item(OP_BYTE, CH_LF);
        send_item(OP_TAKE, 8'hFF);
    endtask

    // Extreme byte values are stored and streamed back; a byte arriving after the line
    // feed is ignored.
    task automatic test_plain_line();
        send_text('{8'h00, 8'hFF, CH_LF, 8'h41});
        send_item(OP_TAKE, 8'h55);
    endtask

    // Mixed case keyword with spaces and tabs around it matches and clears the line.
    task automatic test_abort_line();
        send_text('{CH_SPACE, 8'h61, 8'h42, 8'h6F, 8'h52, 8'h74, CH_TAB, CH_LF});
        send_item(OP_ABORT, 8'hAA);
    endtask

    task automatic test_restart();
        send_text('{8'h71, CH_CR});
        send_item(OP_RESTART, 8'h00);
    endtask

    // A line of exactly BUF_SIZE-1 characters is kept whole; one character more
    // discards the line and the next line starts from nothing.
    task automatic test_full_and_overflow();
        logic [7:0] text [$];
        repeat (BUF_SIZE - 1)
            text.push_back(8'($urandom_range(11, 255)));
        text.push_back(CH_LF);
        send_text(text);
        send_item(OP_TAKE, 8'h00);
        text.delete();
        text.push_back(CH_CR);
        repeat (BUF_SIZE)
            text.push_back(8'($urandom_range(11, 255)));
        text.push_back(8'h6B);
        text.push_back(CH_LF);
        send_text(text);
        send_item(OP_TAKE, 8'h00);
    endtask

    // The receiver stops for a long stretch while a take and more bytes are offered,
    // so the output register fills and the block has to stall its input.
    task automatic test_backpressure();
        logic [7:0] text [$];
        hold_request = 1'b1;
        repeat (12)
            text.push_back(8'($urandom_range(11, 255)));
        text.push_back(CH_LF);
        send_text(text);
        send_item(OP_TAKE, 8'h00);
        repeat (6)
            send_item(OP_BYTE, 8'($urandom_range(11, 255)));
        send_item(OP_BYTE, CH_LF);
        send_item(OP_TAKE, 8'h00);
    endtask

    // Back-to-back traffic with neither side ever idling.
    task automatic test_steady_stream();
        steady = 1'b1;
        repeat (8)
            send_random_sequence();
        steady = 1'b0;
    endtask

    // Random traffic tops the run up to its planned number of input items.
    task automatic test_random_traffic();
        while (counted_items < TOTAL_ITEMS)
            send_random_sequence();
    endtask

    // Receiver: ready changes at the falling edge, idling at random except while the
    // steady stretch runs or a requested hold-off is being counted down.
    initial
    begin
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (steady)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Result checker: every output transfer is compared with the oldest awaited result.
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind %0d data 0x%0h",
                                          m_axis_tuser, m_axis_tdata));
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("kind", 8'(m_axis_tuser), 8'(want.kind));
                check_field("line_char", m_axis_tdata[7:0], want.line_char);
                check_field("last", 8'(m_axis_tlast), 8'(want.last));
                check_field("char_count", 8'(m_axis_tdata[13:8]), 8'(want.char_count));
                check_field("line_ready", 8'(m_axis_tdata[14]), 8'(want.line_ready));
                check_field("cr_seen", 8'(m_axis_tdata[15]), 8'(want.cr_seen));
                check_field("overflowed", 8'(m_axis_tdata[16]), 8'(want.overflowed));
                check_field("abort_match", 8'(m_axis_tdata[17]), 8'(want.abort_match));
                check_field("padding", 8'(m_axis_tdata[23:18]), 8'h00);
            end
            result_index++;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = OP_BYTE;
        error_count   = 0;
        result_index  = 0;
        counted_items = 0;
        steady        = 1'b0;
        hold_request  = 1'b0;
        clear_line();
        foreach (line_chars[i])
            line_chars[i] = 8'h00;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_no_line();
        test_empty_line();
        test_plain_line();
        test_abort_line();
        test_restart();
        test_full_and_overflow();
        test_backpressure();
        test_steady_stream();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        // Let any stray trailing result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
